### hdl/omfh_pkg.sv
// Package: shared constants, status codes and decision type for the mutex bank.
`default_nettype none
package omfh_pkg;

    localparam int NUM_MUTEXES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PID_WIDTH_DEF   = 8;

    localparam int OPCODE_W   = 1;
    localparam int MUTEX_ID_W = 4;
    localparam int PROC_ID_W  = 8;
    localparam int STATUS_W   = 3;

    localparam logic [OPCODE_W-1:0] OP_LOCK   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTLOCKED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOTOWNER  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                table_we;   // rewrite the mutex entry
        logic                waiter_we;  // append requester to the wait queue
        logic                wake;       // fetch oldest waiter, then hand off
    } t_decision;

endpackage
`default_nettype wire

### hdl/omfh_if.sv
// Interfaces: request and response channels of the mutex bank.
`default_nettype none
interface omfh_req_if;
    logic                             valid;
    logic                             ready;
    logic [omfh_pkg::OPCODE_W-1:0]    opcode;
    logic [omfh_pkg::MUTEX_ID_W-1:0]  mutex_id;
    logic [omfh_pkg::PROC_ID_W-1:0]   process_id;

    modport source (output valid, output opcode, output mutex_id, output process_id,
                    input ready);
    modport sink   (input valid, input opcode, input mutex_id, input process_id,
                    output ready);
endinterface

interface omfh_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [omfh_pkg::STATUS_W-1:0]    status;
    logic                             woken_valid;
    logic [omfh_pkg::PROC_ID_W-1:0]   woken_pid;

    modport source (output valid, output status, output woken_valid, output woken_pid,
                    input ready);
    modport sink   (input valid, input status, input woken_valid, input woken_pid,
                    output ready);
endinterface
`default_nettype wire

### hdl/omfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module omfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/omfh_eval.sv
// Request evaluation: decides status and next mutex entry from the entry read.
`default_nettype none
module omfh_eval #(
    parameter int QUEUE_DEPTH = omfh_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_WIDTH   = omfh_pkg::PID_WIDTH_DEF,
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int SW = CW + 1
) (
    input  wire logic [omfh_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [PID_WIDTH-1:0]          i_pid,
    input  wire logic                          i_locked,
    input  wire logic [PID_WIDTH-1:0]          i_owner,
    input  wire logic [HW-1:0]                 i_head,
    input  wire logic [CW-1:0]                 i_count,
    output omfh_pkg::t_decision                o_dec,
    output logic                               o_locked,
    output logic [HW-1:0]                      o_head,
    output logic [CW-1:0]                      o_count,
    output logic [HW-1:0]                      o_tail_slot
);

    logic [SW-1:0] tail_sum;
    logic [SW-1:0] head_sum;

    // tail = (head + count) mod depth; head + count < 2*depth on an enqueue
    always_comb begin
        tail_sum = SW'(i_head) + SW'(i_count);
        if (tail_sum >= SW'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        head_sum = SW'(i_head) + SW'(1);
        if (head_sum >= SW'(QUEUE_DEPTH)) begin
            head_sum = head_sum - SW'(QUEUE_DEPTH);
        end
    end

    assign o_tail_slot = tail_sum[HW-1:0];

    always_comb begin
        o_dec     = '0;
        o_locked  = i_locked;
        o_head    = i_head;
        o_count   = i_count;
        if (i_opcode == omfh_pkg::OP_LOCK) begin
            priority if (!i_locked) begin
                o_dec.status   = omfh_pkg::ST_ACQUIRED;
                o_dec.table_we = 1'b1;
                o_locked       = 1'b1;
            end else if (i_owner == i_pid) begin
                o_dec.status = omfh_pkg::ST_ALREADY;
            end else if (i_count >= CW'(QUEUE_DEPTH)) begin
                o_dec.status = omfh_pkg::ST_FULL;
            end else begin
                o_dec.status    = omfh_pkg::ST_BLOCKED;
                o_dec.table_we  = 1'b1;
                o_dec.waiter_we = 1'b1;
                o_count         = i_count + CW'(1);
            end
        end else begin
            priority if (!i_locked) begin
                o_dec.status = omfh_pkg::ST_NOTLOCKED;
            end else if (i_owner != i_pid) begin
                o_dec.status = omfh_pkg::ST_NOTOWNER;
            end else if (i_count != '0) begin
                o_dec.status = omfh_pkg::ST_HANDOFF;
                o_dec.wake   = 1'b1;
                o_head       = head_sum[HW-1:0];
                o_count      = i_count - CW'(1);
            end else begin
                o_dec.status   = omfh_pkg::ST_FREED;
                o_dec.table_we = 1'b1;
                o_locked       = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/owned_mutex_fifo_handoff_core.sv
// Top level: bank of owned mutexes with FIFO wait queues held in two RAMs.
// Response path: the mutex entry is read from the table RAM, decided in S_EVAL and
// loaded into the output register; on a handoff the oldest waiter is first read
// from the waiter RAM in S_WAKE. One request at a time: a new one is taken only in
// S_IDLE, after the mutex-table read-modify-write; a response held in the output
// register stalls the write-back of the next request until it drains.
// Reset: per-entry valid flops clear at once, so every mutex reads as free with an
// empty queue; no clearing pass, the RAMs themselves are not reset.
`default_nettype none
module owned_mutex_fifo_handoff_core #(
    parameter int NUM_MUTEXES = omfh_pkg::NUM_MUTEXES_DEF,
    parameter int QUEUE_DEPTH = omfh_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_WIDTH   = omfh_pkg::PID_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    omfh_req_if.sink     i_req,
    omfh_rsp_if.source   o_rsp
);

    // Entry field widths
    localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 1 + PID_WIDTH + HW + CW;
    localparam int WAITERS = NUM_MUTEXES * QUEUE_DEPTH;
    localparam int WA = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int IDW = omfh_pkg::MUTEX_ID_W;
    localparam int PXW = omfh_pkg::PROC_ID_W;
    localparam int EXT_W = PID_WIDTH + PXW;

    // Sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request transaction
    localparam logic [1:0] S_EVAL = 2'd1;   // mutex entry read data is valid
    localparam logic [1:0] S_WAKE = 2'd2;   // oldest waiter read data is valid

    logic [1:0]             r_state, n_state;
    logic [omfh_pkg::OPCODE_W-1:0] r_opcode;
    logic [PID_WIDTH-1:0]   r_pid;
    logic [MW-1:0]          r_mutex;
    logic                   r_rd_valid;
    logic [NUM_MUTEXES-1:0] r_entry_valid;

    logic                            r_out_valid;
    logic [omfh_pkg::STATUS_W-1:0]   r_out_status;
    logic                            r_out_woken_valid;
    logic [PXW-1:0]                  r_out_woken_pid;

    // ------------------------------------------------------------------
    // Mutex index wraps modulo the bank size: small constant lookup
    // ------------------------------------------------------------------
    logic [MW-1:0] mod_lut [2**IDW];
    for (genvar g = 0; g < 2**IDW; g++) begin : g_mod
        localparam int ModVal = g % NUM_MUTEXES;
        assign mod_lut[g] = MW'(ModVal);
    end

    logic [MW-1:0]        req_mutex;
    logic [EXT_W-1:0]     req_pid_ext;
    logic [PID_WIDTH-1:0] req_pid;

    assign req_mutex   = mod_lut[i_req.mutex_id];
    assign req_pid_ext = EXT_W'(i_req.process_id);
    assign req_pid     = req_pid_ext[PID_WIDTH-1:0];

    logic req_fire;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Output register may be reloaded when empty or drained this cycle
    logic out_free;
    assign out_free = !r_out_valid || o_rsp.ready;

    // ------------------------------------------------------------------
    // Mutex table RAM: {locked, owner, head, count}
    // ------------------------------------------------------------------
    logic          tbl_we;
    logic [EW-1:0] tbl_wdata;
    logic [EW-1:0] tbl_rdata;

    omfh_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_MUTEXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_mutex),
        .i_wdata (tbl_wdata),
        .i_re    (req_fire),
        .i_raddr (req_mutex),
        .o_rdata (tbl_rdata)
    );

    // An entry never written reads as free with an empty queue
    logic [EW-1:0]        entry;
    logic                 ent_locked;
    logic [PID_WIDTH-1:0] ent_owner;
    logic [HW-1:0]        ent_head;
    logic [CW-1:0]        ent_count;

    assign entry = r_rd_valid ? tbl_rdata : '0;
    assign {ent_locked, ent_owner, ent_head, ent_count} = entry;

    // Owner changes only when a free mutex is taken; a handoff overrides it below
    logic [PID_WIDTH-1:0] nxt_owner;
    assign nxt_owner = ent_locked ? ent_owner : r_pid;

    // ------------------------------------------------------------------
    // Decision logic
    // ------------------------------------------------------------------
    omfh_pkg::t_decision dec;
    logic                nxt_locked;
    logic [HW-1:0]       nxt_head;
    logic [CW-1:0]       nxt_count;
    logic [HW-1:0]       tail_slot;

    omfh_eval #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_WIDTH   (PID_WIDTH)
    ) u_eval (
        .i_opcode    (r_opcode),
        .i_pid       (r_pid),
        .i_locked    (ent_locked),
        .i_owner     (ent_owner),
        .i_head      (ent_head),
        .i_count     (ent_count),
        .o_dec       (dec),
        .o_locked    (nxt_locked),
        .o_head      (nxt_head),
        .o_count     (nxt_count),
        .o_tail_slot (tail_slot)
    );

    // ------------------------------------------------------------------
    // Waiter RAM: queue of mutex m occupies rows m*depth .. m*depth+depth-1
    // ------------------------------------------------------------------
    logic [WA-1:0]        wait_base;
    logic [WA-1:0]        wait_waddr;
    logic [WA-1:0]        wait_raddr;
    logic                 wait_we;
    logic                 wait_re;
    logic [PID_WIDTH-1:0] wait_rdata;

    assign wait_base  = WA'(r_mutex) * WA'(QUEUE_DEPTH);
    assign wait_waddr = wait_base + WA'(tail_slot);
    assign wait_raddr = wait_base + WA'(ent_head);

    omfh_ram #(
        .WIDTH (PID_WIDTH),
        .DEPTH (WAITERS)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (wait_we),
        .i_waddr (wait_waddr),
        .i_wdata (r_pid),
        .i_re    (wait_re),
        .i_raddr (wait_raddr),
        .o_rdata (wait_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: one request at a time, read / decide / write back
    // ------------------------------------------------------------------
    logic finish;

    always_comb begin
        n_state   = r_state;
        tbl_we    = 1'b0;
        tbl_wdata = {nxt_locked, nxt_owner, nxt_head, nxt_count};
        wait_we   = 1'b0;
        wait_re   = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (dec.wake) begin
                    // head waiter needed before the entry can be rewritten
                    wait_re = 1'b1;
                    n_state = S_WAKE;
                end else if (out_free) begin
                    tbl_we  = dec.table_we;
                    wait_we = dec.waiter_we;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WAKE: begin
                // entry read data holds: the table RAM reads only on a new request
                tbl_wdata = {1'b1, wait_rdata, nxt_head, nxt_count};
                if (out_free) begin
                    tbl_we  = 1'b1;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Woken pid is reported in the 8-bit response field
    logic [EXT_W-1:0] woken_ext;
    assign woken_ext = EXT_W'(wait_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_fire) begin
                r_rd_valid <= r_entry_valid[req_mutex];
            end
            if (tbl_we) begin
                r_entry_valid[r_mutex] <= 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_opcode <= i_req.opcode;
            r_pid    <= req_pid;
            r_mutex  <= req_mutex;
        end
        if (finish) begin
            r_out_status      <= dec.status;
            r_out_woken_valid <= (r_state == S_WAKE);
            r_out_woken_pid   <= (r_state == S_WAKE) ? woken_ext[PXW-1:0] : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.woken_valid = r_out_woken_valid;
    assign o_rsp.woken_pid   = r_out_woken_pid;

endmodule
`default_nettype wire
